// ===== hdl/fsd_pkg.sv =====
`default_nettype none

package fsd_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_ROWS  = 1024;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH = CFG_W'(720);
    localparam logic [CFG_W-1:0] RST_FRAME_ROWS  = CFG_W'(576);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_FIRST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = 2'd3;

    // Input item modes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/fsd_if.sv =====
`default_nettype none

interface fsd_in_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [fsd_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface fsd_out_if;
    logic                     valid;
    logic                     ready;
    logic [fsd_pkg::PIX_W-1:0] pixel_out;
    logic                     second_frame;
    logic                     last_of_frame;
    logic                     not_ready;

    modport source (output valid, output pixel_out, output second_frame,
                    output last_of_frame, output not_ready, input ready);
    modport sink   (input valid, input pixel_out, input second_frame,
                    input last_of_frame, input not_ready, output ready);
endinterface

`default_nettype wire

// ===== hdl/fsd_frame_store.sv =====
`default_nettype none

// Single-port frame memory with a registered read.
module fsd_frame_store #(
    parameter int DEPTH = fsd_pkg::DEF_MAX_WIDTH * fsd_pkg::DEF_MAX_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             addr,
    input  wire logic [fsd_pkg::PIX_W-1:0] wdata,
    output logic      [fsd_pkg::PIX_W-1:0] rdata
);
    import fsd_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== hdl/field_separating_deinterlacer_core.sv =====
`default_nettype none

// Channel  | Direction | Handshake   | Payload
// ---------+-----------+-------------+-----------------------------------------------
// in_ch    | sink      | valid/ready | mode, pixel_in
// out_ch   | source    | valid/ready | pixel_out, second_frame, last_of_frame, not_ready
// cfg      | sink      | cfg_we only | cfg_index, cfg_data
//
// A load is taken in S_IDLE. A request steps S_ADR_A, S_DATA, S_EMIT for a copied or
// duplicated line, S_ADR_A, S_ADR_B, S_SUM, S_EMIT for a line average, and goes to
// S_EMIT at once when answered with not_ready; the single frame-memory port and the
// shared adder, which forms both read addresses and the pixel sum, set these steps.
// Reset clears all counters and restores the default geometry; the frame memory is
// not cleared. A stalled output holds its item and the block waits in its emit state.
module field_separating_deinterlacer_core #(
    parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = fsd_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fsd_pkg::CFG_W-1:0]     cfg_data,
    fsd_in_if.sink                             in_ch,
    fsd_out_if.source                          out_ch
);
    import fsd_pkg::*;

    // Memory depth and the widths of the address, column and row counters.
    localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    // The shared adder must hold an address and the 9-bit sum of two pixels.
    localparam int AL    = (AW > PIX_W + 1) ? AW : PIX_W + 1;
    // Compare widths for clamping the 11-bit geometry registers.
    localparam int CMW   = (WCW > CFG_W) ? WCW : CFG_W;
    localparam int CMR   = (RCW > CFG_W) ? RCW : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADR_A,
        S_ADR_B,
        S_SUM,
        S_DATA,
        S_EMIT
    } state_t;

    // How the pending output pixel is formed.
    typedef enum logic [1:0] {
        K_KEEP,
        K_DUP,
        K_AVG
    } kind_t;

    state_t             state_reg,     state_next;
    kind_t              kind_reg,      kind_next;
    logic               field_reg,     field_next;
    logic               nr_reg,        nr_next;

    logic [CFG_W-1:0]   width_reg,     width_next;
    logic [CFG_W-1:0]   rows_reg,      rows_next;
    logic               odd_first_reg, odd_first_next;
    logic               interp_reg,    interp_next;

    logic [AW-1:0]      load_addr_reg, load_addr_next;
    logic [WCW-1:0]     load_col_reg,  load_col_next;
    logic [RCW-1:0]     load_row_reg,  load_row_next;
    logic               complete_reg,  complete_next;

    logic [AW-1:0]      out_addr_reg,  out_addr_next;
    logic [WCW-1:0]     out_col_reg,   out_col_next;
    logic [RCW-1:0]     out_row_reg,   out_row_next;
    logic               phase_reg,     phase_next;

    logic [PIX_W-1:0]   pix_a_reg,     pix_a_next;
    logic [PIX_W-1:0]   pix_reg,       pix_next;

    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_pix_reg,   out_pix_next;
    logic               out_sec_reg,   out_sec_next;
    logic               out_last_reg,  out_last_next;
    logic               out_nr_reg,    out_nr_next;

    // Effective geometry.
    logic [CMW-1:0]     width_ext;
    logic [CMR-1:0]     rows_ext;
    logic [WCW-1:0]     w_eff;
    logic [RCW-1:0]     rows_eff;
    logic [RCW-1:0]     last_row;

    // Shared adder.
    logic [AL-1:0]      alu_a;
    logic [AL-1:0]      alu_b;
    logic               alu_sub;
    logic [AL-1:0]      alu_out;

    // Frame memory port.
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [PIX_W-1:0]   mem_q;

    logic               in_fire;
    logic               out_free;
    logic               cur_field;
    logic               top_pair;
    logic               bottom_pair;
    logic               last_pix;

    // Clamp the width to 1..MAX_WIDTH and the row count to 2..MAX_ROWS.
    always_comb
    begin
        width_ext = CMW'(width_reg);
        rows_ext  = CMR'(rows_reg);
        if (width_ext == '0)
        begin
            w_eff = WCW'(1);
        end
        else if (width_ext > CMW'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext[WCW-1:0];
        end
        if (rows_ext < CMR'(2))
        begin
            rows_eff = RCW'(2);
        end
        else if (rows_ext > CMR'(MAX_ROWS))
        begin
            rows_eff = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_ext[RCW-1:0];
        end
    end

    // Index of the last emitted row: an odd trailing source row is dropped.
    assign last_row = {rows_eff[RCW-1:1], 1'b0} - RCW'(1);

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign cur_field   = odd_first_reg ^ phase_reg;
    assign top_pair    = (out_row_reg[RCW-1:1] == '0);
    assign bottom_pair = ((out_row_reg | RCW'(1)) == last_row);
    assign last_pix    = (out_row_reg == last_row) && (out_col_reg == w_eff - WCW'(1));

    // The neighbouring rows of a pixel sit exactly one line, w_eff entries, away
    // in the raster-ordered memory, so each read address is the current output
    // address or that address plus or minus the line width. The same adder later sums two pixels.
    always_comb
    begin
        alu_a   = AL'(out_addr_reg);
        alu_b   = AL'(w_eff);
        alu_sub = 1'b0;
        case (state_reg)
            S_ADR_A:
            begin
                // Kept row of the pair: above it for the even field, below for odd.
                if (kind_reg == K_KEEP)
                begin
                    alu_b = '0;
                end
                alu_sub = !field_reg;
            end
            S_ADR_B:
            begin
                // The kept row on the other side of the missing line.
                alu_sub = field_reg;
            end
            S_SUM:
            begin
                alu_a = AL'(pix_a_reg);
                alu_b = AL'(mem_q);
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
        alu_out = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign mem_we   = in_fire && (in_ch.mode == MODE_LOAD) && !complete_reg;
    assign mem_addr = (state_reg == S_IDLE) ? load_addr_reg : alu_out[AW-1:0];

    fsd_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_ch.pixel_in),
        .rdata (mem_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        field_next     = field_reg;
        nr_next        = nr_reg;
        width_next     = width_reg;
        rows_next      = rows_reg;
        odd_first_next = odd_first_reg;
        interp_next    = interp_reg;
        load_addr_next = load_addr_reg;
        load_col_next  = load_col_reg;
        load_row_next  = load_row_reg;
        complete_next  = complete_reg;
        out_addr_next  = out_addr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        phase_next     = phase_reg;
        pix_a_next     = pix_a_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pix_next   = out_pix_reg;
        out_sec_next   = out_sec_reg;
        out_last_next  = out_last_reg;
        out_nr_next    = out_nr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.mode == MODE_LOAD))
                begin
                    // Loads after the frame is complete are dropped.
                    if (!complete_reg)
                    begin
                        load_addr_next = load_addr_reg + AW'(1);
                        if (load_col_reg == w_eff - WCW'(1))
                        begin
                            load_col_next = '0;
                            load_row_next = load_row_reg + RCW'(1);
                            if (load_row_reg == rows_eff - RCW'(1))
                            begin
                                complete_next = 1'b1;
                            end
                        end
                        else
                        begin
                            load_col_next = load_col_reg + WCW'(1);
                        end
                    end
                end
                else if (in_fire)
                begin
                    field_next = cur_field;
                    nr_next    = !complete_reg;
                    pix_next   = '0;
                    if (out_row_reg[0] == cur_field)
                    begin
                        kind_next = K_KEEP;
                    end
                    else if (interp_reg && !(cur_field && top_pair)
                             && !(!cur_field && bottom_pair))
                    begin
                        kind_next = K_AVG;
                    end
                    else
                    begin
                        kind_next = K_DUP;
                    end
                    state_next = complete_reg ? S_ADR_A : S_EMIT;
                end
            end
            S_ADR_A:
            begin
                state_next = (kind_reg == K_AVG) ? S_ADR_B : S_DATA;
            end
            S_ADR_B:
            begin
                pix_a_next = mem_q;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                pix_next   = alu_out[PIX_W:1];
                state_next = S_EMIT;
            end
            S_DATA:
            begin
                pix_next   = mem_q;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pix_reg;
                    out_nr_next    = nr_reg;
                    out_sec_next   = !nr_reg && phase_reg;
                    out_last_next  = !nr_reg && last_pix;
                    state_next     = S_IDLE;
                    if (!nr_reg)
                    begin
                        if (last_pix)
                        begin
                            out_addr_next = '0;
                            out_col_next  = '0;
                            out_row_next  = '0;
                            phase_next    = 1'b1;
                            if (phase_reg)
                            begin
                                // Both frames are out: start over with a new load.
                                phase_next     = 1'b0;
                                complete_next  = 1'b0;
                                load_addr_next = '0;
                                load_col_next  = '0;
                                load_row_next  = '0;
                            end
                        end
                        else
                        begin
                            out_addr_next = out_addr_reg + AW'(1);
                            if (out_col_reg == w_eff - WCW'(1))
                            begin
                                out_col_next = '0;
                                out_row_next = out_row_reg + RCW'(1);
                            end
                            else
                            begin
                                out_col_next = out_col_reg + WCW'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Any register write abandons the frame in progress.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH: width_next     = cfg_data;
                REG_FRAME_ROWS:  rows_next      = cfg_data;
                REG_ODD_FIRST:   odd_first_next = cfg_data[0];
                REG_INTERPOLATE: interp_next    = cfg_data[0];
                default:         width_next     = width_reg;
            endcase
            load_addr_next = '0;
            load_col_next  = '0;
            load_row_next  = '0;
            complete_next  = 1'b0;
            out_addr_next  = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            phase_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_KEEP;
            field_reg     <= 1'b0;
            nr_reg        <= 1'b0;
            width_reg     <= RST_FRAME_WIDTH;
            rows_reg      <= RST_FRAME_ROWS;
            odd_first_reg <= 1'b0;
            interp_reg    <= 1'b0;
            load_addr_reg <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            complete_reg  <= 1'b0;
            out_addr_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            phase_reg     <= 1'b0;
            pix_a_reg     <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_sec_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
            out_nr_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            field_reg     <= field_next;
            nr_reg        <= nr_next;
            width_reg     <= width_next;
            rows_reg      <= rows_next;
            odd_first_reg <= odd_first_next;
            interp_reg    <= interp_next;
            load_addr_reg <= load_addr_next;
            load_col_reg  <= load_col_next;
            load_row_reg  <= load_row_next;
            complete_reg  <= complete_next;
            out_addr_reg  <= out_addr_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            phase_reg     <= phase_next;
            pix_a_reg     <= pix_a_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_sec_reg   <= out_sec_next;
            out_last_reg  <= out_last_next;
            out_nr_reg    <= out_nr_next;
        end
    end

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_out     = out_pix_reg;
    assign out_ch.second_frame  = out_sec_reg;
    assign out_ch.last_of_frame = out_last_reg;
    assign out_ch.not_ready     = out_nr_reg;

endmodule

`default_nettype wire

// ===== hdl/fsd_checker.sv =====
`default_nettype none

module fsd_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      in_mode,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [fsd_pkg::PIX_W-1:0] out_pixel,
    input wire logic                      out_second,
    input wire logic                      out_last,
    input wire logic                      out_nr
);
    import fsd_pkg::*;

    // A not_ready answer carries no pixel, frame or end-of-frame information.
    a_nr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_nr) |-> (out_pixel == '0) && !out_second && !out_last)
        else $error("not_ready item carries nonzero fields");

    // A request keeps the block busy for at least the next cycle.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_mode == MODE_REQUEST)) |=> !in_ready)
        else $error("input accepted right after a request");

    // A load never produces a result item.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_mode == MODE_LOAD)) |=> !$rose(out_valid))
        else $error("result item appeared after a load");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_pixel)
            && $stable(out_second) && $stable(out_last) && $stable(out_nr))
        else $error("stalled result item changed");

endmodule

bind field_separating_deinterlacer_core fsd_checker u_fsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pixel  (out_ch.pixel_out),
    .out_second (out_ch.second_frame),
    .out_last   (out_ch.last_of_frame),
    .out_nr     (out_ch.not_ready)
);

`default_nettype wire

// ===== verif/tb_field_separating_deinterlacer_core.sv =====
`timescale 1ns / 1ps

module tb_field_separating_deinterlacer_core;

    import fsd_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_R       = DEF_MAX_ROWS;
    localparam int STORE_DEPTH = MAX_W * MAX_R;
    localparam int IDLE_PCT    = 38;
    localparam int RANDOM_ITEMS = 1150;
    // Cycles allowed after the last result so that a load still in flight settles.
    localparam int SETTLE_CYCLES = 8;
    // A load cut short stops within this many pixels, so that frames at the
    // largest geometry stay within the item budget.
    localparam int LOAD_CUT_MAX = 200;

    // One item on the input channel.
    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pix;
    } pixel_item_t;

    // One item on the output channel, in the order of its fields.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             second_frame;
        logic             last_of_frame;
        logic             not_ready;
    } deint_result_t;

    // How a random phase exercises one frame: a full load and a full
    // emission of both output frames, or a frame cut short by a register
    // write during its load or during its emission.
    typedef enum int {
        SHAPE_WHOLE,
        SHAPE_CUT_LOAD,
        SHAPE_CUT_EMIT
    } phase_shape_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fsd_in_if  in_ch ();
    fsd_out_if out_ch ();

    field_separating_deinterlacer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Items waiting to be driven, and pixels the block still owes us.
    pixel_item_t   pending_items[$];
    deint_result_t exp_pixels[$];

    int  n_errors;
    int  queued_items;
    bit  in_fired;
    // While calm is set, neither side of the block ever idles.
    bit  calm;

    // Our own copy of the block's registers and its frame bookkeeping.
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_rows;
    logic             cfg_odd;
    logic             cfg_interp;
    int               loaded_cnt;
    bit               frame_done;
    int               emit_row;
    int               emit_col;
    bit               emit_phase;
    bit [PIX_W-1:0]   pix_mem [STORE_DEPTH];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. The slowest legal run, with both sides idling,
    // stays well below a tenth of this.
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Geometry as the block uses it: width clamped to 1..MAX_W and the row
    // count clamped to 2..MAX_R.
    function automatic void frame_geometry(output int w, output int rows);
        w    = (cfg_width < 1) ? 1 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        rows = (cfg_rows < 2) ? 2 : (cfg_rows > MAX_R) ? MAX_R : int'(cfg_rows);
    endfunction

    function automatic void restart_emission();
        loaded_cnt = 0;
        frame_done = 1'b0;
        emit_row   = 0;
        emit_col   = 0;
        emit_phase = 1'b0;
    endfunction

    function automatic logic [PIX_W-1:0] mem_at(input int row, input int col,
                                                input int w);
        int a;
        a = row * w + col;
        return (a < STORE_DEPTH) ? pix_mem[a] : '0;
    endfunction

    // Advances the frame model by one accepted item and queues the pixel
    // that a request must produce.
    function automatic void deint_step(input logic mode, input logic [PIX_W-1:0] pix);
        int w;
        int rows;
        int ny;
        int fld;
        int y;
        int other;
        deint_result_t res;
        frame_geometry(w, rows);
        ny  = rows / 2;
        res = '0;
        if (mode == MODE_LOAD)
        begin
            // A load while a complete frame waits to be emitted is dropped.
            if (!frame_done)
            begin
                if (loaded_cnt < w * rows)
                begin
                    pix_mem[loaded_cnt] = pix;
                    loaded_cnt++;
                end
                if (loaded_cnt >= w * rows)
                    frame_done = 1'b1;
            end
        end
        else if (!frame_done || emit_row >= 2 * ny || emit_col >= w)
        begin
            res.not_ready = 1'b1;
            exp_pixels.push_back(res);
        end
        else
        begin
            fld = int'(cfg_odd ^ emit_phase);
            y   = emit_row / 2;
            if ((emit_row % 2) == fld)
            begin
                // Row of the kept field: straight copy.
                res.pixel = mem_at(emit_row, emit_col, w);
            end
            else if (cfg_interp && !(fld == 1 && y == 0)
                     && !(fld == 0 && y == ny - 1))
            begin
                // Missing row with kept rows on both sides: floor average.
                other = (fld == 0) ? 2 * y + 2 : 2 * y - 1;
                res.pixel = PIX_W'((int'(mem_at(other, emit_col, w)) +
                                    int'(mem_at(2 * y + fld, emit_col, w))) >> 1);
            end
            else
            begin
                // Duplicated row, or a missing row at the top or bottom edge.
                res.pixel = mem_at(2 * y + fld, emit_col, w);
            end
            res.second_frame  = emit_phase;
            res.last_of_frame = (emit_row == 2 * ny - 1) && (emit_col == w - 1);
            exp_pixels.push_back(res);

            if (res.last_of_frame)
            begin
                emit_row = 0;
                emit_col = 0;
                if (!emit_phase)
                    emit_phase = 1'b1;
                else
                    restart_emission();
            end
            else if (emit_col + 1 >= w)
            begin
                emit_col = 0;
                emit_row++;
            end
            else
            begin
                emit_col++;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                        input logic [PIX_W-1:0] got);
        if (got !== want)
        begin
            n_errors++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // The input valid is held until the item is taken; in_fired tells the
    // driver at the falling edge whether the previous rising edge took it.
    always @(negedge clk)
    begin : driver
        pixel_item_t nxt;
        if (rst_n)
        begin
            if (!in_ch.valid || in_fired)
            begin
                if (pending_items.size() > 0 && !take_break())
                begin
                    nxt = pending_items.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.mode     <= nxt.mode;
                    in_ch.pixel_in <= nxt.pix;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= !take_break();
        end
    end

    // Both handshakes are observed at the rising edge. A taken item updates
    // the model first, so a result is always compared with the oldest pixel
    // still owed.
    always @(posedge clk)
    begin : monitor
        deint_result_t want;
        in_fired <= in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                deint_step(in_ch.mode, in_ch.pixel_in);
            if (out_ch.valid && out_ch.ready)
            begin
                if (exp_pixels.size() == 0)
                begin
                    n_errors++;
                    $error("unexpected result: pixel_out %0d, not_ready %0b",
                           out_ch.pixel_out, out_ch.not_ready);
                end
                else
                begin
                    want = exp_pixels.pop_front();
                    check_field("pixel_out", want.pixel, out_ch.pixel_out);
                    check_field("second_frame", PIX_W'(want.second_frame),
                                PIX_W'(out_ch.second_frame));
                    check_field("last_of_frame", PIX_W'(want.last_of_frame),
                                PIX_W'(out_ch.last_of_frame));
                    check_field("not_ready", PIX_W'(want.not_ready),
                                PIX_W'(out_ch.not_ready));
                end
            end
        end
    end

    task automatic push_item(input logic mode, input logic [PIX_W-1:0] pix);
        pixel_item_t it;
        it.mode = mode;
        it.pix  = pix;
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Returns once every queued item has been taken, every owed pixel has
    // arrived and a load still in flight has had time to land.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid || exp_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; any write also aborts the frame in progress.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: cfg_width  = data;
            REG_FRAME_ROWS:  cfg_rows   = data;
            REG_ODD_FIRST:   cfg_odd    = data[0];
            REG_INTERPOLATE: cfg_interp = data[0];
            default:         cfg_width  = cfg_width;
        endcase
        restart_emission();
    endtask

    // Sets up a new geometry and queues one frame's worth of traffic. The
    // field-order and averaging registers get random 11-bit data, so their
    // upper bits are exercised as well. A few stray requests go in during
    // the load and a few stray loads during the emission.
    task automatic random_phase(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] r_val,
                                input phase_shape_t shape, output int n_items);
        int w;
        int rows;
        int n_load;
        int n_req;
        int cut;
        int start;
        int k;
        start = queued_items;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_ROWS, r_val);
        write_reg(REG_ODD_FIRST, CFG_W'($urandom_range(0, 2047)));
        write_reg(REG_INTERPOLATE, CFG_W'($urandom_range(0, 2047)));
        frame_geometry(w, rows);
        n_load = w * rows;
        n_req  = 4 * w * (rows / 2);

        if (shape == SHAPE_CUT_LOAD)
            cut = $urandom_range(0, (n_load - 1 < LOAD_CUT_MAX) ? n_load - 1 : LOAD_CUT_MAX);
        else
            cut = n_load;
        for (k = 0; k < cut; k++)
        begin
            if ($urandom_range(99) < 4)
                push_item(MODE_REQUEST, PIX_W'($urandom));
            push_item(MODE_LOAD, PIX_W'($urandom));
        end
        if (shape != SHAPE_CUT_LOAD)
        begin
            cut = (shape == SHAPE_CUT_EMIT) ? $urandom_range(1, n_req - 1) : n_req;
            for (k = 0; k < cut; k++)
            begin
                if ($urandom_range(99) < 4)
                    push_item(MODE_LOAD, PIX_W'($urandom));
                push_item(MODE_REQUEST, PIX_W'($urandom));
            end
            if (shape == SHAPE_WHOLE)
            begin
                // Past the end of both frames: requests are refused, and a
                // load begins the next frame, which the next write discards.
                repeat ($urandom_range(0, 2)) push_item(MODE_REQUEST, PIX_W'($urandom));
                repeat ($urandom_range(0, 2)) push_item(MODE_LOAD, PIX_W'($urandom));
                if ($urandom_range(1))
                    push_item(MODE_REQUEST, PIX_W'($urandom));
            end
        end
        n_items = queued_items - start;
    endtask

    initial
    begin : stimulus
        int           random_count;
        int           n_items;
        int           ph;
        int           pick;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] r_val;
        phase_shape_t shape;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_LOAD;
        in_ch.pixel_in = '0;
        out_ch.ready   = 1'b0;
        calm           = 1'b0;
        n_errors       = 0;
        queued_items   = 0;
        cfg_width      = RST_FRAME_WIDTH;
        cfg_rows       = RST_FRAME_ROWS;
        cfg_odd        = 1'b0;
        cfg_interp     = 1'b0;
        restart_emission();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Right after reset nothing is loaded, so a request is refused. One
        // load at the default geometry starts a frame that the following
        // register writes throw away.
        push_item(MODE_REQUEST, 8'hFF);
        push_item(MODE_LOAD, 8'hA5);
        wait_idle();

        // A one-pixel-wide frame of five rows: the fifth row is never
        // emitted. With averaging and the even field first, row 1 is the
        // average of 255 and 0, row 3 sits on the bottom edge and is copied,
        // and in the second frame row 0 sits on the top edge. The average of
        // two 255 values checks that the sum keeps its carry.
        write_reg(REG_FRAME_WIDTH, CFG_W'(1));
        write_reg(REG_FRAME_ROWS, CFG_W'(5));
        write_reg(REG_ODD_FIRST, CFG_W'(0));
        write_reg(REG_INTERPOLATE, CFG_W'(1));
        push_item(MODE_REQUEST, 8'h00);
        push_item(MODE_LOAD, 8'hFF);
        push_item(MODE_LOAD, 8'hFF);
        push_item(MODE_LOAD, 8'h00);
        push_item(MODE_LOAD, 8'hFF);
        push_item(MODE_LOAD, 8'h09);
        // The frame is complete, so this load is dropped.
        push_item(MODE_LOAD, 8'h77);
        repeat (4) push_item(MODE_REQUEST, 8'h00);
        push_item(MODE_LOAD, 8'h05);
        repeat (4) push_item(MODE_REQUEST, 8'hFF);
        // Both frames are out; the block refuses until a new frame loads.
        push_item(MODE_REQUEST, 8'h00);
        wait_idle();

        // Odd field first, duplication, and a width written as zero.
        write_reg(REG_ODD_FIRST, CFG_W'(1));
        write_reg(REG_INTERPOLATE, CFG_W'(0));
        write_reg(REG_FRAME_WIDTH, CFG_W'(0));
        write_reg(REG_FRAME_ROWS, CFG_W'(2));
        push_item(MODE_LOAD, 8'h00);
        push_item(MODE_LOAD, 8'hC3);
        repeat (4) push_item(MODE_REQUEST, 8'h3C);

        // Random frames of small geometry, with a stretch in the middle
        // where neither side idles and two loads at the largest geometry,
        // each cut short by the next register write: one with the width
        // clamped to its maximum and one with the row count clamped to its
        // maximum.
        random_count = 0;
        for (ph = 0; random_count < RANDOM_ITEMS; ph++)
        begin
            calm = (ph >= 5 && ph <= 8);
            if (ph == 6)
            begin
                random_phase(CFG_W'(2047), CFG_W'(1), SHAPE_CUT_LOAD, n_items);
                random_count += n_items;
            end
            if (ph == 12)
            begin
                random_phase(CFG_W'(0), CFG_W'(2047), SHAPE_CUT_LOAD, n_items);
                random_count += n_items;
            end

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                w_val = CFG_W'(0);
                r_val = CFG_W'($urandom_range(0, 9));
            end
            else if (pick == 1)
            begin
                w_val = CFG_W'($urandom_range(16, 40));
                r_val = CFG_W'($urandom_range(2, 4));
            end
            else
            begin
                w_val = CFG_W'($urandom_range(1, 8));
                r_val = CFG_W'($urandom_range(0, 9));
            end

            pick = $urandom_range(0, 99);
            shape = (pick < 75) ? SHAPE_WHOLE : (pick < 87) ? SHAPE_CUT_LOAD : SHAPE_CUT_EMIT;
            random_phase(w_val, r_val, shape, n_items);
            random_count += n_items;
        end
        calm = 1'b0;

        wait_idle();
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== field_separating_deinterlacer_core.f =====
hdl/fsd_pkg.sv
hdl/fsd_if.sv
hdl/fsd_frame_store.sv
hdl/field_separating_deinterlacer_core.sv
hdl/fsd_checker.sv
verif/tb_field_separating_deinterlacer_core.sv
